@@ rtl/salsa_pkg.sv @@
// ----------------------------------------------------------------------------
// salsa_pkg
// shared constants and helpers for the salsa20 keystream generator
// ----------------------------------------------------------------------------
`default_nettype none
package salsa_pkg;
  localparam int DOUBLE_ROUNDS = 10;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_TAKE   = 2'd1;
  localparam logic [1:0] KIND_SKIP   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_NONCE = 3'd4;
  localparam logic [2:0] REG_START = 3'd5;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  typedef logic [31:0] mat_t [16];

  function automatic mat_t quarter(input mat_t m, input int a, input int b,
                                   input int c, input int d);
    mat_t r;
    r = m;
    r[b] = r[b] ^ rotl(r[a] + r[d], 7);
    r[c] = r[c] ^ rotl(r[b] + r[a], 9);
    r[d] = r[d] ^ rotl(r[c] + r[b], 13);
    r[a] = r[a] ^ rotl(r[d] + r[c], 18);
    quarter = r;
  endfunction

  // four parallel quarter rounds: column half when row is 0, row half else
  function automatic mat_t half_round(input mat_t m, input logic row);
    mat_t r;
    r = m;
    if (!row) begin
      r = quarter(r, 0, 4, 8, 12);
      r = quarter(r, 5, 9, 13, 1);
      r = quarter(r, 10, 14, 2, 6);
      r = quarter(r, 15, 3, 7, 11);
    end else begin
      r = quarter(r, 0, 1, 2, 3);
      r = quarter(r, 5, 6, 7, 4);
      r = quarter(r, 10, 11, 8, 9);
      r = quarter(r, 15, 12, 13, 14);
    end
    half_round = r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/salsa_ram.sv @@
// ----------------------------------------------------------------------------
// salsa_ram
// generic single-port-write, one-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module salsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/salsa20_keystream_generator_core.sv @@
// ----------------------------------------------------------------------------
// salsa20_keystream_generator_core
// salsa20/20 keystream generator with the block held in a 16x32 ram
// ----------------------------------------------------------------------------
// channel  direction  contents
// in       slave      tdata = kind[1:0], byte_count[8:2]
// out      master     tdata = stream_byte, tlast = last_byte
// cfg      apb        six 64-bit registers at 8*i
// a new block runs the half rounds in S_RND, then writes the block to the ram in S_WR.
// a take or skip of n bytes walks a byte a cycle while not stalled, plus the ram
// read states S_RD and S_WAIT for each 32-bit block word it enters, plus a new
// block when the buffer empties. reset is synchronous; the ram content is not
// cleared, a take after reset first builds a block. out_tready low stalls a take's byte walk.
`default_nettype none
module salsa20_keystream_generator_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,    // kind[1:0], byte_count[8:2], zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,   // stream_byte[7:0]
  output logic        out_tlast,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [5:0]  cfg_paddr,
  input  wire  [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RND  = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_r, sblk_r;
  logic [63:0] ctr_r;
  logic [6:0]  left_r;
  logic [2:0]  st_r;
  logic [4:0]  rnd_r;
  logic [3:0]  wi_r;
  logic [1:0]  kind_r;
  logic [6:0]  cnt_r;
  salsa_pkg::mat_t m_r, init;
  logic [31:0] word_r;
  logic        we;
  logic [3:0]  raddr;
  logic [31:0] rdata;
  logic [2:0]  cidx;

  assign cfg_pready = 1'b1;
  assign cidx = cfg_paddr[5:3];
  always_comb begin
    case (cidx)
      salsa_pkg::REG_KEY0:  cfg_prdata = key0_r;
      salsa_pkg::REG_KEY1:  cfg_prdata = key1_r;
      salsa_pkg::REG_KEY2:  cfg_prdata = key2_r;
      salsa_pkg::REG_KEY3:  cfg_prdata = key3_r;
      salsa_pkg::REG_NONCE: cfg_prdata = nonce_r;
      salsa_pkg::REG_START: cfg_prdata = sblk_r;
      default:              cfg_prdata = 64'd0;
    endcase
  end

  always_comb begin
    init[0]  = salsa_pkg::SIGMA0;  init[1]  = key0_r[31:0];
    init[2]  = key0_r[63:32];      init[3]  = key1_r[31:0];
    init[4]  = key1_r[63:32];      init[5]  = salsa_pkg::SIGMA1;
    init[6]  = nonce_r[31:0];      init[7]  = nonce_r[63:32];
    init[8]  = ctr_r[31:0];        init[9]  = ctr_r[63:32];
    init[10] = salsa_pkg::SIGMA2;  init[11] = key2_r[31:0];
    init[12] = key2_r[63:32];      init[13] = key3_r[31:0];
    init[14] = key3_r[63:32];      init[15] = salsa_pkg::SIGMA3;
  end

  assign we = (st_r == S_WR);
  assign raddr = 4'((7'd64 - left_r) >> 2);

  salsa_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
    .clk(clk), .we(we), .waddr(wi_r), .wdata(m_r[wi_r] + init[wi_r]),
    .raddr(raddr), .rdata(rdata)
  );

  logic [1:0] boff;
  assign boff = 2'(7'd64 - left_r);
  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT) && (kind_r == salsa_pkg::KIND_TAKE);
  assign out_tdata = 8'(word_r >> {boff, 3'b000});
  assign out_tlast = (cnt_r == 7'd1);

  logic [1:0] ikind;
  logic [6:0] icnt;
  assign ikind = in_tdata[1:0];
  assign icnt  = in_tdata[8:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0; key1_r <= '0; key2_r <= '0; key3_r <= '0;
      nonce_r <= '0; sblk_r <= '0; ctr_r <= '0; left_r <= '0;
      st_r <= S_IDLE; rnd_r <= '0; wi_r <= '0; kind_r <= '0; cnt_r <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cidx)
          salsa_pkg::REG_KEY0:  key0_r  <= cfg_pwdata;
          salsa_pkg::REG_KEY1:  key1_r  <= cfg_pwdata;
          salsa_pkg::REG_KEY2:  key2_r  <= cfg_pwdata;
          salsa_pkg::REG_KEY3:  key3_r  <= cfg_pwdata;
          salsa_pkg::REG_NONCE: nonce_r <= cfg_pwdata;
          salsa_pkg::REG_START: sblk_r  <= cfg_pwdata;
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r <= ikind;
            cnt_r  <= (icnt > 7'd64) ? 7'd64 : icnt;
            if (ikind == salsa_pkg::KIND_START) begin
              ctr_r <= sblk_r; rnd_r <= '0; st_r <= S_RND;
            end else if (ikind != salsa_pkg::KIND_UNUSED && icnt != 7'd0) begin
              if (left_r == 7'd0) begin
                ctr_r <= ctr_r + 64'd1; rnd_r <= '0; st_r <= S_RND;
              end else begin
                st_r <= S_RD;
              end
            end
          end
        end
        S_RND: begin
          if (rnd_r == 5'd0) begin
            m_r <= salsa_pkg::half_round(init, 1'b0);
          end else begin
            m_r <= salsa_pkg::half_round(m_r, rnd_r[0]);
          end
          if (rnd_r == 5'(2 * salsa_pkg::DOUBLE_ROUNDS - 1)) begin
            wi_r <= '0; st_r <= S_WR;
          end
          rnd_r <= rnd_r + 5'd1;
        end
        S_WR: begin
          wi_r <= wi_r + 4'd1;
          if (wi_r == 4'd15) begin
            left_r <= 7'd64;
            st_r <= (kind_r == salsa_pkg::KIND_START || cnt_r == 7'd0) ? S_IDLE : S_RD;
          end
        end
        S_RD:   st_r <= S_WAIT;
        S_WAIT: begin word_r <= rdata; st_r <= S_OUT; end
        S_OUT: begin
          if (kind_r != salsa_pkg::KIND_TAKE || out_tready) begin
            left_r <= left_r - 7'd1;
            cnt_r  <= cnt_r - 7'd1;
            if (left_r == 7'd1) begin
              ctr_r <= ctr_r + 64'd1; rnd_r <= '0; st_r <= S_RND;
            end else if (cnt_r == 7'd1) begin
              st_r <= S_IDLE;
            end else if (boff == 2'd3) begin
              st_r <= S_RD;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
